@@ design/sed_pkg.sv @@
// Shared types, codes and lookup functions for the string escape decoder.
`timescale 1ns / 1ps
`default_nettype none
package sed_pkg;

  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_ESC  = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_CUT_ESC = 3'd1;
  localparam logic [2:0] ST_CUT_HEX = 3'd2;
  localparam logic [2:0] ST_CUT_UNI = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;
  localparam logic [2:0] ST_BAD_HEX = 3'd5;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_U         = 8'h75;

  localparam logic [2:0] DIGITS_HEX = 3'd2;
  localparam logic [2:0] DIGITS_UNI = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } item_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       out_last;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } lookup_t;

  function automatic lookup_t hex_value(input logic [7:0] c);
    lookup_t r;
    r.hit   = 1'b1;
    r.value = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = c - 8'h37;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

  function automatic lookup_t simple_escape(input logic [7:0] c);
    lookup_t r;
    r.hit = 1'b1;
    case (c)
      8'h6E:   r.value = 8'h0A;
      8'h74:   r.value = 8'h09;
      8'h72:   r.value = 8'h0D;
      8'h30:   r.value = 8'h00;
      8'h5C:   r.value = 8'h5C;
      8'h27:   r.value = 8'h27;
      8'h22:   r.value = 8'h22;
      8'h62:   r.value = 8'h08;
      8'h66:   r.value = 8'h0C;
      8'h76:   r.value = 8'h0B;
      8'h61:   r.value = 8'h07;
      default: begin
        r.hit   = 1'b0;
        r.value = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/sed_if.sv @@
// Valid/ready stream interfaces for raw input bytes and decoded results.
`timescale 1ns / 1ps
`default_nettype none
interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface sed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       out_last;
  modport source (output valid, output out_byte, output status, output out_last, input ready);
  modport sink (input valid, input out_byte, input status, input out_last, output ready);
endinterface
`default_nettype wire

@@ design/string_escape_decoder.sv @@
// Top level of the C string escape decoder.
// Decodes one raw byte per cycle, back to back, while results are taken: a
// byte lands in the input register, the escape state machine decodes it
// once the result register is open, and its result (if any) lands in the
// result register, which drives the result channel.
// A backslash that opens an escape, the x or u after it and all but the last hex digit of \x or \u produce
// no result; every other byte and every final byte produce exactly one.
// Throughput is set only by the result channel: while it accepts, a new byte
// is taken every cycle.
`timescale 1ns / 1ps
`default_nettype none
module string_escape_decoder (
  input  logic      clk,
  input  logic      rst_n,
  sed_in_if.sink    in_if,
  sed_out_if.source out_if
);

  logic             s1_vld;
  sed_pkg::item_t   s1_item;
  sed_pkg::result_t res;
  logic             out_open;
  logic             adv;

  assign adv = s1_vld && out_open;

  sed_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .adv   (adv),
    .vld   (s1_vld),
    .item  (s1_item)
  );

  sed_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (s1_item),
    .res   (res)
  );

  sed_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (adv),
    .res    (res),
    .out_if (out_if),
    .open   (out_open)
  );

endmodule
`default_nettype wire

@@ design/sed_in_reg.sv @@
// Input register stage holding one raw byte transfer.
`timescale 1ns / 1ps
`default_nettype none
module sed_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  sed_in_if.sink         in_if,
  input  logic           adv,
  output logic           vld,
  output sed_pkg::item_t item
);

  logic           vld_r;
  sed_pkg::item_t item_r;

  assign in_if.ready = !vld_r || adv;
  assign vld         = vld_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      vld_r <= 1'b1;
    end else if (adv) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      item_r.in_byte <= in_if.in_byte;
      item_r.in_last <= in_if.in_last;
    end
  end

endmodule
`default_nettype wire

@@ design/sed_decode.sv @@
// Escape decode state and next-state logic, one byte per cycle while fire is high.
`timescale 1ns / 1ps
`default_nettype none
module sed_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  sed_pkg::item_t   item,
  output sed_pkg::result_t res
);

  logic [1:0] mode_r, mode_nxt;
  logic [2:0] digits_r, digits_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic       uni_r, uni_nxt;

  sed_pkg::lookup_t simple;
  sed_pkg::lookup_t hexv;
  logic [7:0]       acc_sh;
  logic [2:0]       digits_dec;
  logic             is_uni;

  always_comb begin
    simple     = sed_pkg::simple_escape(item.in_byte);
    hexv       = sed_pkg::hex_value(item.in_byte);
    acc_sh     = {acc_r[3:0], hexv.value[3:0]};
    digits_dec = digits_r - 3'd1;
    is_uni     = (item.in_byte == sed_pkg::CH_U);

    mode_nxt     = sed_pkg::MODE_TEXT;
    digits_nxt   = 3'd0;
    acc_nxt      = 8'h00;
    uni_nxt      = 1'b0;
    res.emit     = 1'b0;
    res.out_byte = 8'h00;
    res.status   = sed_pkg::ST_OK;
    res.out_last = item.in_last;

    case (mode_r)
      sed_pkg::MODE_ESC: begin
        if (simple.hit) begin
          res.emit     = 1'b1;
          res.out_byte = simple.value;
        end else if (item.in_byte == sed_pkg::CH_X || is_uni) begin
          if (item.in_last) begin
            res.emit   = 1'b1;
            res.status = is_uni ? sed_pkg::ST_CUT_UNI : sed_pkg::ST_CUT_HEX;
          end else begin
            mode_nxt   = sed_pkg::MODE_HEX;
            digits_nxt = is_uni ? sed_pkg::DIGITS_UNI : sed_pkg::DIGITS_HEX;
            uni_nxt    = is_uni;
          end
        end else begin
          res.emit   = 1'b1;
          res.status = sed_pkg::ST_UNKNOWN;
        end
      end
      sed_pkg::MODE_HEX: begin
        if (!hexv.hit) begin
          res.emit   = 1'b1;
          res.status = sed_pkg::ST_BAD_HEX;
        end else if (digits_dec == 3'd0) begin
          res.emit     = 1'b1;
          res.out_byte = acc_sh;
        end else if (item.in_last) begin
          res.emit   = 1'b1;
          res.status = uni_r ? sed_pkg::ST_CUT_UNI : sed_pkg::ST_CUT_HEX;
        end else begin
          mode_nxt   = sed_pkg::MODE_HEX;
          digits_nxt = digits_dec;
          acc_nxt    = acc_sh;
          uni_nxt    = uni_r;
        end
      end
      default: begin
        if (item.in_byte == sed_pkg::CH_BACKSLASH) begin
          if (item.in_last) begin
            res.emit   = 1'b1;
            res.status = sed_pkg::ST_CUT_ESC;
          end else begin
            mode_nxt = sed_pkg::MODE_ESC;
          end
        end else begin
          res.emit     = 1'b1;
          res.out_byte = item.in_byte;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= sed_pkg::MODE_TEXT;
      digits_r <= 3'd0;
      acc_r    <= 8'h00;
      uni_r    <= 1'b0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      digits_r <= digits_nxt;
      acc_r    <= acc_nxt;
      uni_r    <= uni_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/sed_out_reg.sv @@
// Result register stage driving the decoded byte channel.
`timescale 1ns / 1ps
`default_nettype none
module sed_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  sed_pkg::result_t res,
  sed_out_if.source        out_if,
  output logic             open
);

  logic       vld_r;
  logic [7:0] byte_r;
  logic [2:0] status_r;
  logic       last_r;

  assign open            = !vld_r || out_if.ready;
  assign out_if.valid    = vld_r;
  assign out_if.out_byte = byte_r;
  assign out_if.status   = status_r;
  assign out_if.out_last = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load && res.emit) begin
      vld_r <= 1'b1;
    end else if (out_if.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.emit) begin
      byte_r   <= res.out_byte;
      status_r <= res.status;
      last_r   <= res.out_last;
    end
  end

endmodule
`default_nettype wire

@@ test/string_escape_decoder_tb.sv @@
// Self-checking testbench for string_escape_decoder: directed and random escaped strings.
`timescale 1ns / 1ps
module string_escape_decoder_tb;

  class decode_tracker;
    typedef struct {
      logic [7:0] data;
      logic [2:0] status;
      logic       last;
    } decoded_t;

    decoded_t   expected_q[$];
    logic [1:0] mode;
    logic [2:0] digits_left;
    logic [7:0] acc;
    logic       uni;
    int         errors;
    int         checked;
    int         status_hits[6];

    function new();
      clear();
      errors  = 0;
      checked = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    static function int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    static function int escape_byte(logic [7:0] c);
      case (c)
        "n":                   return 8'h0A;
        "t":                   return 8'h09;
        "r":                   return 8'h0D;
        "0":                   return 8'h00;
        sed_pkg::CH_BACKSLASH: return 8'h5C;
        "'":                   return 8'h27;
        "\"":                  return 8'h22;
        "b":                   return 8'h08;
        "f":                   return 8'h0C;
        "v":                   return 8'h0B;
        "a":                   return 8'h07;
        default:               return -1;
      endcase
    endfunction

    function void clear();
      mode        = sed_pkg::MODE_TEXT;
      digits_left = '0;
      acc         = '0;
      uni         = 1'b0;
    endfunction

    function void push(logic [7:0] d, logic [2:0] st, logic l);
      decoded_t e;
      e.data   = d;
      e.status = st;
      e.last   = l;
      expected_q.insert(expected_q.size(), e);
      clear();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the decode state by one accepted input byte.
    function void note_byte(logic [7:0] c, logic last);
      int m;
      int v;
      m = escape_byte(c);
      v = hex_digit(c);
      if (mode == sed_pkg::MODE_ESC) begin
        if (m >= 0) begin
          push(m[7:0], sed_pkg::ST_OK, last);
        end else if (c == sed_pkg::CH_X || c == sed_pkg::CH_U) begin
          if (last) begin
            push(8'h00, (c == sed_pkg::CH_U) ? sed_pkg::ST_CUT_UNI : sed_pkg::ST_CUT_HEX, 1'b1);
          end else begin
            mode        = sed_pkg::MODE_HEX;
            digits_left = (c == sed_pkg::CH_U) ? sed_pkg::DIGITS_UNI : sed_pkg::DIGITS_HEX;
            acc         = '0;
            uni         = (c == sed_pkg::CH_U);
          end
        end else begin
          push(8'h00, sed_pkg::ST_UNKNOWN, last);
        end
      end else if (mode == sed_pkg::MODE_HEX) begin
        if (v < 0) begin
          push(8'h00, sed_pkg::ST_BAD_HEX, last);
        end else begin
          acc         = {acc[3:0], v[3:0]};
          digits_left = digits_left - 3'd1;
          if (digits_left == 3'd0) begin
            push(acc, sed_pkg::ST_OK, last);
          end else if (last) begin
            push(8'h00, uni ? sed_pkg::ST_CUT_UNI : sed_pkg::ST_CUT_HEX, 1'b1);
          end
        end
      end else if (c == sed_pkg::CH_BACKSLASH) begin
        if (last) begin
          push(8'h00, sed_pkg::ST_CUT_ESC, 1'b1);
        end else begin
          mode = sed_pkg::MODE_ESC;
        end
      end else begin
        push(c, sed_pkg::ST_OK, last);
      end
    endfunction

    function void check_decoded(logic [7:0] d, logic [2:0] st, logic l);
      decoded_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: byte %h status %0d last %0b",
                 $time, d, st, l);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (st < 6) status_hits[st]++;
      if (d !== e.data) begin
        errors++;
        $display("%0t: out_byte expected %h actual %h", $time, e.data, d);
      end
      if (st !== e.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
      end
      if (l !== e.last) begin
        errors++;
        $display("%0t: out_last expected %0b actual %0b", $time, e.last, l);
      end
    endfunction
  endclass

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_THIRDS, RX_BLOCKS} rx_pattern_e;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TARGET_BYTES   = 1750;

  logic clk;
  logic rst_n;

  sed_in_if  in_if ();
  sed_out_if out_if ();

  string_escape_decoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  decode_tracker tracker = new();

  logic [7:0]  text_q[$];
  int          burst_left;
  int          sent_bytes;
  int          sent_strings;
  int          idle_cycles;
  int          rx_count;
  rx_pattern_e rx_pattern;

  string esc_letters = "ntr0\\'\"bfva";
  string hex_chars   = "0123456789abcdefABCDEF";

  always #4 clk = ~clk;

  // Receiver stall pattern: switch to a random style whenever the low six bits of rx_count are zero.
  always @(negedge clk) begin
    rx_count <= rx_count + 1;
    if (rx_count[5:0] == 6'd0) rx_pattern <= rx_pattern_e'($urandom_range(0, 3));
    case (rx_pattern)
      RX_OPEN:   out_if.ready <= 1'b1;
      RX_COIN:   out_if.ready <= ($urandom_range(0, 3) != 0);
      RX_THIRDS: out_if.ready <= (rx_count % 3 != 0);
      RX_BLOCKS: out_if.ready <= rx_count[3];
      default:   out_if.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) tracker.note_byte(in_if.in_byte, in_if.in_last);
      if (out_if.valid && out_if.ready)
        tracker.check_decoded(out_if.out_byte, out_if.status, out_if.out_last);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic hold_idle(int n);
    repeat (n) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
  endtask

  task automatic send_byte(logic [7:0] c, logic last);
    if (burst_left == 0) begin
      hold_idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_if.valid   <= 1'b1;
    in_if.in_byte <= c;
    in_if.in_last <= last;
    do @(posedge clk); while (!in_if.ready);
    sent_bytes++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    sent_strings++;
  endtask

  task automatic send_queue();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    sent_strings++;
  endtask

  function automatic logic [7:0] pick_hex();
    return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
  endfunction

  function automatic void append_byte(logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  function automatic void add_token();
    logic [7:0] c;
    int         kind;
    int         n;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      c = 8'($urandom_range(0, 255));
      while (c == sed_pkg::CH_BACKSLASH) c = 8'($urandom_range(0, 255));
      append_byte(c);
    end else if (kind < 58) begin
      append_byte(sed_pkg::CH_BACKSLASH);
      append_byte(esc_letters[$urandom_range(0, esc_letters.len() - 1)]);
    end else if (kind < 72) begin
      append_byte(sed_pkg::CH_BACKSLASH);
      append_byte(sed_pkg::CH_X);
      repeat (2) append_byte(pick_hex());
    end else if (kind < 84) begin
      append_byte(sed_pkg::CH_BACKSLASH);
      append_byte(sed_pkg::CH_U);
      repeat (4) append_byte(pick_hex());
    end else if (kind < 90) begin
      c = 8'($urandom_range(0, 255));
      while (decode_tracker::escape_byte(c) >= 0 || c == sed_pkg::CH_X || c == sed_pkg::CH_U)
        c = 8'($urandom_range(0, 255));
      append_byte(sed_pkg::CH_BACKSLASH);
      append_byte(c);
    end else begin
      // Hex escape broken by a non-digit.
      n = $urandom_range(0, 1);
      append_byte(sed_pkg::CH_BACKSLASH);
      append_byte(n ? sed_pkg::CH_U : sed_pkg::CH_X);
      repeat ($urandom_range(0, n ? 3 : 1)) append_byte(pick_hex());
      c = 8'($urandom_range(0, 255));
      while (decode_tracker::hex_digit(c) >= 0) c = 8'($urandom_range(0, 255));
      append_byte(c);
    end
  endfunction

  function automatic void build_string();
    int cut;
    text_q.delete();
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 10)) append_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) add_token();
    end
    // Sometimes cut the string short, which can end it inside an escape.
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, text_q.size());
      while (text_q.size() > cut) text_q.delete(text_q.size() - 1);
    end
  endfunction

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.in_last = 1'b0;
    out_if.ready  = 1'b0;
    rx_count      = 0;
    rx_pattern    = RX_OPEN;
    idle_cycles   = 0;
    burst_left    = 0;
    sent_bytes    = 0;
    sent_strings  = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("\\n");
    send_text("\\x41");
    send_text("\\uFfe9");
    send_text("\\");
    send_text("\\x");
    send_text("\\u1");
    send_text("\\q");
    send_text("\\xg");

    while (sent_bytes < TARGET_BYTES) begin
      build_string();
      send_queue();
    end
    @(negedge clk);
    in_if.valid <= 1'b0;

    while (tracker.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d strings (%0d bytes), checked %0d decoded results",
             sent_strings, sent_bytes, tracker.checked);
    $display("Status mix: ok %0d, cut esc %0d, cut hex %0d, cut uni %0d,",
             tracker.status_hits[0], tracker.status_hits[1], tracker.status_hits[2],
             tracker.status_hits[3], " unknown %0d, bad hex %0d",
             tracker.status_hits[4], tracker.status_hits[5]);
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/sed_pkg.sv
design/sed_if.sv
design/sed_in_reg.sv
design/sed_decode.sv
design/sed_out_reg.sv
design/string_escape_decoder.sv
test/string_escape_decoder_tb.sv
